@@ hdl/pwm_tone_sequence_player_unit_assert.svh @@
// Assertion macros shared by the tone sequence player modules.
`ifndef PWM_TONE_SEQUENCE_PLAYER_UNIT_ASSERT_SVH
`define PWM_TONE_SEQUENCE_PLAYER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PTS_ASSERT_SAME(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define PTS_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

@@ hdl/pts_pkg.sv @@
// Types, constants and note tables of the tone sequence player.
`timescale 1ns / 1ps

package pts_pkg;

   // Field widths fixed by the item format.
   localparam int unsigned FREQ_W     = 16;
   localparam int unsigned DUTY_W     = 8;
   localparam int unsigned DUR_W      = 16;
   localparam int unsigned CHAR_W     = 8;
   localparam int unsigned BPM_W      = 10;
   localparam int unsigned NOTE_NUM_W = 17;

   // Operation codes.
   localparam logic [1:0] OP_ADD_TONE = 2'd0;
   localparam logic [1:0] OP_ADD_NOTE = 2'd1;
   localparam logic [1:0] OP_FLUSH    = 2'd2;
   localparam logic [1:0] OP_TICK     = 2'd3;

   // Fixed musical constants.
   localparam int unsigned NOMINAL_BEAT = 16;
   localparam int unsigned MS_PER_S     = 1000;
   localparam int unsigned SEC_PER_MIN  = 60;
   localparam logic [DUTY_W-1:0] NOTE_DUTY  = 8'd50;
   localparam logic [FREQ_W-1:0] DEFAULT_HZ = 16'd440;
   localparam logic [DUR_W-1:0]  DUR_MAX    = 16'hFFFF;

   // Milliseconds to ticks: the rate splits into whole and fractional thousands,
   // and the fractional part is divided by 1000 through a reciprocal product that
   // is exact for every dividend below 2^26.
   localparam int unsigned TPS_HI_W       = 7;
   localparam int unsigned TPS_LO_W       = 10;
   localparam int unsigned MS_RECIP_SHIFT = 36;
   localparam int unsigned MS_RECIP_W     = 27;
   localparam logic [MS_RECIP_W-1:0] MS_RECIP = MS_RECIP_W'(
      ((64'd1 << MS_RECIP_SHIFT) + 64'(MS_PER_S) - 64'd1) / 64'(MS_PER_S));

   // ASCII codes of modifiers and length letters.
   localparam logic [CHAR_W-1:0] CHAR_SHARP  = 8'h23;
   localparam logic [CHAR_W-1:0] CHAR_FLAT   = 8'h5F;
   localparam logic [CHAR_W-1:0] CHAR_MINIM  = 8'h6D;
   localparam logic [CHAR_W-1:0] CHAR_QUAVER = 8'h71;
   localparam logic [CHAR_W-1:0] CHAR_SEMI   = 8'h73;
   localparam logic [CHAR_W-1:0] CHAR_DEMI   = 8'h64;
   localparam logic [CHAR_W-1:0] CHAR_HEMI   = 8'h68;

   // Note duration numerators: ((len * 1000) / 16) * 60, integer steps.
   localparam int unsigned NUM_MINIM  =
      (((NOMINAL_BEAT * 2) * MS_PER_S) / NOMINAL_BEAT) * SEC_PER_MIN;
   localparam int unsigned NUM_CROTCH =
      ((NOMINAL_BEAT * MS_PER_S) / NOMINAL_BEAT) * SEC_PER_MIN;
   localparam int unsigned NUM_QUAVER =
      (((NOMINAL_BEAT / 2) * MS_PER_S) / NOMINAL_BEAT) * SEC_PER_MIN;
   localparam int unsigned NUM_SEMI   =
      (((NOMINAL_BEAT / 4) * MS_PER_S) / NOMINAL_BEAT) * SEC_PER_MIN;
   localparam int unsigned NUM_DEMI   =
      (((NOMINAL_BEAT / 8) * MS_PER_S) / NOMINAL_BEAT) * SEC_PER_MIN;
   localparam int unsigned NUM_HEMI   =
      (((NOMINAL_BEAT / 16) * MS_PER_S) / NOMINAL_BEAT) * SEC_PER_MIN;

   // Note table: letters and their whole-Hz frequencies.
   localparam int unsigned NOTE_COUNT = 26;
   localparam int unsigned NOTE_IDX_W = 5;
   localparam logic [CHAR_W-1:0] NOTE_NAMES [NOTE_COUNT] = '{
      8'h53, 8'h5A, 8'h41, 8'h41, 8'h42, 8'h43, 8'h43, 8'h44, 8'h44,
      8'h45, 8'h46, 8'h46, 8'h47, 8'h47,
      8'h61, 8'h61, 8'h62, 8'h63, 8'h63, 8'h64, 8'h64, 8'h65, 8'h66,
      8'h66, 8'h67, 8'h67
   };
   localparam logic [FREQ_W-1:0] NOTE_HZ [NOTE_COUNT] = '{
      16'd0,   16'd207, 16'd220, 16'd238, 16'd246, 16'd261, 16'd277,
      16'd293, 16'd311, 16'd329, 16'd349, 16'd369, 16'd392, 16'd415,
      16'd440, 16'd466, 16'd493, 16'd523, 16'd554, 16'd587, 16'd622,
      16'd659, 16'd698, 16'd739, 16'd783, 16'd830
   };

   // One queued tone.
   typedef struct packed {
      logic [FREQ_W-1:0] freq;
      logic [DUR_W-1:0]  dur;
      logic [DUTY_W-1:0] duty;
   } tone_type;

   // Frequency of a note; the first matching letter wins, and a
   // modifier that would step off either end of the table stays put.
   function automatic logic [FREQ_W-1:0] note_hz_lookup(
      input logic [CHAR_W-1:0] letter,
      input logic [CHAR_W-1:0] modif
   );
      logic [NOTE_IDX_W-1:0] idx;
      logic [NOTE_IDX_W-1:0] sel;
      logic                  found;
      idx   = '0;
      found = 1'b0;
      for (int i = NOTE_COUNT - 1; i >= 0; i--) begin
         if (NOTE_NAMES[i] == letter) begin
            idx   = NOTE_IDX_W'(i);
            found = 1'b1;
         end
      end
      sel = idx;
      if (modif == CHAR_SHARP) begin
         if (idx != NOTE_IDX_W'(NOTE_COUNT - 1)) begin
            sel = idx + 1'b1;
         end
      end else if (modif == CHAR_FLAT) begin
         if (idx != '0) begin
            sel = idx - 1'b1;
         end
      end
      return found ? NOTE_HZ[sel] : DEFAULT_HZ;
   endfunction

   // Duration numerator of a length code; unknown codes are crotchets.
   function automatic logic [NOTE_NUM_W-1:0] note_numerator(
      input logic [CHAR_W-1:0] code
   );
      logic [NOTE_NUM_W-1:0] num;
      unique case (code)
         CHAR_MINIM:  num = NOTE_NUM_W'(NUM_MINIM);
         CHAR_QUAVER: num = NOTE_NUM_W'(NUM_QUAVER);
         CHAR_SEMI:   num = NOTE_NUM_W'(NUM_SEMI);
         CHAR_DEMI:   num = NOTE_NUM_W'(NUM_DEMI);
         CHAR_HEMI:   num = NOTE_NUM_W'(NUM_HEMI);
         default:     num = NOTE_NUM_W'(NUM_CROTCH);
      endcase
      return num;
   endfunction

endpackage

@@ hdl/pts_tone_store.sv @@
// Tone queue memory with one write port and one registered read port.
`timescale 1ns / 1ps

module pts_tone_store
   import pts_pkg::*;
#(
   parameter int unsigned DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  tone_type                 wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output tone_type                 rd_data
);

   tone_type mem [DEPTH];
   tone_type rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port: data appears the cycle after rd_en.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/pts_divider.sv @@
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps
`include "pwm_tone_sequence_player_unit_assert.svh"

module pts_divider
   import pts_pkg::*;
#(
   parameter int unsigned DIVIDEND_W = 26,
   parameter int unsigned DIVISOR_W  = 10
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  go,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient
);

   localparam int unsigned CNT_W = $clog2(DIVIDEND_W + 1);

   logic                  busy_ff;
   logic                  done_ff;
   logic [CNT_W-1:0]      count_ff;
   logic [DIVIDEND_W-1:0] num_ff;
   logic [DIVISOR_W-1:0]  rem_ff;
   logic [DIVISOR_W-1:0]  dvs_ff;
   logic [DIVISOR_W:0]    trial;
   logic                  fits;

   // Trial subtraction of the next partial remainder.
   assign trial = {rem_ff, num_ff[DIVIDEND_W-1]};
   assign fits  = (trial >= {1'b0, dvs_ff});

   // Iteration control and datapath.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (go) begin
            busy_ff  <= 1'b1;
            count_ff <= CNT_W'(DIVIDEND_W);
            num_ff   <= dividend;
            rem_ff   <= '0;
            dvs_ff   <= divisor;
         end else if (busy_ff) begin
            num_ff   <= {num_ff[DIVIDEND_W-2:0], fits};
            rem_ff   <= fits ? DIVISOR_W'(trial - {1'b0, dvs_ff})
                             : DIVISOR_W'(trial);
            count_ff <= count_ff - 1'b1;
            if (count_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = num_ff;

   `PTS_ASSERT_SAME(a_no_go_while_busy, clock, reset, go, !busy_ff)
   `PTS_ASSERT_NEXT(a_done_single_pulse, clock, reset, done_ff, !done_ff)
   `PTS_ASSERT_SAME(a_nonzero_divisor, clock, reset, go, divisor != '0)

endmodule

@@ hdl/pwm_tone_sequence_player_unit.sv @@
// Top level of the tone sequence player: queue control, timing and response.
// Flush and ticks that start no tone answer in the cycle after acceptance; other adds
// answer from the enqueue state. A tone start (add while idle, or tick at tone end)
// passes enqueue or fetch, two multiply stages for the ms to tick scaling, and the
// final sum. A note add with a nonzero tempo runs the serial tempo division first.
// One transaction at a time; results cannot be stalled. Reset is synchronous.
`timescale 1ns / 1ps
`include "pwm_tone_sequence_player_unit_assert.svh"

module pwm_tone_sequence_player_unit
   import pts_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH      = 8,
   parameter int unsigned TICKS_PER_SECOND = 1000
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [1:0]        req_op,
   input  logic [FREQ_W-1:0] req_tone_freq,
   input  logic [DUTY_W-1:0] req_tone_duty,
   input  logic [DUR_W-1:0]  req_tone_duration_ms,
   input  logic [CHAR_W-1:0] req_note_letter,
   input  logic [CHAR_W-1:0] req_note_modifier,
   input  logic [CHAR_W-1:0] req_note_length,
   input  logic [BPM_W-1:0]  req_beats_per_minute,
   output logic              rsp_valid,
   output logic              rsp_accepted,
   output logic              rsp_pwm_changed,
   output logic [FREQ_W-1:0] rsp_pwm_freq,
   output logic [DUTY_W-1:0] rsp_pwm_duty,
   output logic              rsp_playing
);

   // Widths derived from the parameters.
   localparam int unsigned IDX_W = $clog2(QUEUE_DEPTH);
   localparam longint unsigned PROD_MAX =
      64'(DUR_MAX) * 64'(TICKS_PER_SECOND);
   localparam int unsigned TICK_W = $clog2(PROD_MAX / MS_PER_S + 1);
   localparam int unsigned TPS_HI = TICKS_PER_SECOND / MS_PER_S;
   localparam int unsigned TPS_LO = TICKS_PER_SECOND % MS_PER_S;
   localparam int unsigned HI_PROD_W    = DUR_W + TPS_HI_W;
   localparam int unsigned LO_PROD_W    = DUR_W + TPS_LO_W;
   localparam int unsigned SCALE_PROD_W = LO_PROD_W + MS_RECIP_W;
   localparam int unsigned SCALE_Q_W    = SCALE_PROD_W - MS_RECIP_SHIFT;
   localparam logic [TPS_HI_W-1:0] TPS_HI_C = TPS_HI_W'(TPS_HI);
   localparam logic [TPS_LO_W-1:0] TPS_LO_C = TPS_LO_W'(TPS_LO);
   localparam logic [IDX_W-1:0]    LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_NOTE_GO,
      ST_NOTE_WAIT,
      ST_ENQUEUE,
      ST_LOAD,
      ST_MUL,
      ST_SCALE,
      ST_SUM
   } state_type;

   state_type             state_ff;
   logic [IDX_W-1:0]      write_index_ff;
   logic [IDX_W-1:0]      read_index_ff;
   logic                  playing_ff;
   logic [TICK_W-1:0]     ticks_ff;
   logic [FREQ_W-1:0]     out_freq_ff;
   logic [DUTY_W-1:0]     out_duty_ff;
   logic                  rsp_valid_ff;
   logic                  accepted_ff;
   logic                  changed_ff;
   logic [FREQ_W-1:0]     pend_freq_ff;
   logic [DUTY_W-1:0]     pend_duty_ff;
   logic [DUR_W-1:0]      pend_dur_ff;
   logic [NOTE_NUM_W-1:0] note_num_ff;
   logic [BPM_W-1:0]      bpm_ff;
   logic [HI_PROD_W-1:0]  scale_hi_ff;
   logic [LO_PROD_W-1:0]  scale_lo_ff;
   logic [SCALE_Q_W-1:0]  scale_q_ff;

   logic                     take;
   logic [IDX_W-1:0]         write_next;
   logic [IDX_W-1:0]         read_next;
   logic                     full;
   logic                     last_tick;
   logic                     wr_en;
   logic                     rd_en;
   tone_type                 wr_tone;
   tone_type                 rd_tone;
   logic [HI_PROD_W-1:0]     mul_hi;
   logic [LO_PROD_W-1:0]     mul_lo;
   logic [SCALE_PROD_W-1:0]  recip_full;
   logic                     div_go;
   logic                     div_done;
   logic [NOTE_NUM_W-1:0]    div_quot;
   logic [DUR_W-1:0]         note_ms;

   // Ring index arithmetic and queue status.
   assign take       = start && (state_ff == ST_IDLE);
   assign write_next = (write_index_ff == LAST_IDX) ? '0 : write_index_ff + 1'b1;
   assign read_next  = (read_index_ff == LAST_IDX) ? '0 : read_index_ff + 1'b1;
   assign full       = (write_next == read_index_ff);
   assign last_tick  = (ticks_ff <= TICK_W'(1));

   // Memory accesses: enqueue writes, a tone change on a tick reads ahead.
   assign wr_en   = (state_ff == ST_ENQUEUE) && !full;
   assign wr_tone = '{freq: pend_freq_ff, dur: pend_dur_ff, duty: pend_duty_ff};
   assign rd_en   = take && (req_op == OP_TICK) && playing_ff && last_tick &&
                    (read_index_ff != write_index_ff);

   pts_tone_store #(
      .DEPTH (QUEUE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (write_index_ff),
      .wr_data (wr_tone),
      .rd_en   (rd_en),
      .rd_addr (read_index_ff),
      .rd_data (rd_tone)
   );

   // Serial divider for the tempo division of notes.
   assign div_go = (state_ff == ST_NOTE_GO);

   pts_divider #(
      .DIVIDEND_W (NOTE_NUM_W),
      .DIVISOR_W  (BPM_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .go       (div_go),
      .dividend (note_num_ff),
      .divisor  (bpm_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

   // Note length saturates at the largest duration.
   assign note_ms = (|div_quot[NOTE_NUM_W-1:DUR_W]) ? DUR_MAX : div_quot[DUR_W-1:0];

   // Tone length in ticks: whole thousands of the rate times ms, plus the
   // fractional thousands scaled and divided by 1000 through the reciprocal.
   assign mul_hi     = pend_dur_ff * TPS_HI_C;
   assign mul_lo     = pend_dur_ff * TPS_LO_C;
   assign recip_full = scale_lo_ff * MS_RECIP;

   // Sequencer with the player state and the response registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         write_index_ff <= '0;
         read_index_ff  <= '0;
         playing_ff     <= 1'b0;
         ticks_ff       <= '0;
         out_freq_ff    <= '0;
         out_duty_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
         accepted_ff    <= 1'b0;
         changed_ff     <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  accepted_ff  <= 1'b0;
                  changed_ff   <= 1'b0;
                  pend_freq_ff <= (req_op == OP_ADD_NOTE)
                                  ? note_hz_lookup(req_note_letter, req_note_modifier)
                                  : req_tone_freq;
                  pend_duty_ff <= (req_op == OP_ADD_NOTE) ? NOTE_DUTY : req_tone_duty;
                  pend_dur_ff  <= req_tone_duration_ms;
                  note_num_ff  <= note_numerator(req_note_length);
                  bpm_ff       <= req_beats_per_minute;
                  unique case (req_op)
                     OP_ADD_TONE: begin
                        state_ff <= ST_ENQUEUE;
                     end
                     OP_ADD_NOTE: begin
                        if (req_beats_per_minute == '0) begin
                           pend_dur_ff <= DUR_MAX;
                           state_ff    <= ST_ENQUEUE;
                        end else begin
                           state_ff <= ST_NOTE_GO;
                        end
                     end
                     OP_FLUSH: begin
                        write_index_ff <= '0;
                        read_index_ff  <= '0;
                        if (playing_ff) begin
                           out_freq_ff <= '0;
                           out_duty_ff <= '0;
                           playing_ff  <= 1'b0;
                           ticks_ff    <= '0;
                           changed_ff  <= 1'b1;
                        end
                        rsp_valid_ff <= 1'b1;
                     end
                     OP_TICK: begin
                        if (!playing_ff) begin
                           rsp_valid_ff <= 1'b1;
                        end else if (!last_tick) begin
                           ticks_ff     <= ticks_ff - 1'b1;
                           rsp_valid_ff <= 1'b1;
                        end else if (read_index_ff == write_index_ff) begin
                           // Queue ran dry: stop the output.
                           out_freq_ff  <= '0;
                           out_duty_ff  <= '0;
                           playing_ff   <= 1'b0;
                           ticks_ff     <= '0;
                           changed_ff   <= 1'b1;
                           rsp_valid_ff <= 1'b1;
                        end else begin
                           changed_ff <= 1'b1;
                           state_ff   <= ST_LOAD;
                        end
                     end
                  endcase
               end
            end
            ST_NOTE_GO: begin
               state_ff <= ST_NOTE_WAIT;
            end
            ST_NOTE_WAIT: begin
               if (div_done) begin
                  pend_dur_ff <= note_ms;
                  state_ff    <= ST_ENQUEUE;
               end
            end
            ST_ENQUEUE: begin
               if (full) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end else begin
                  write_index_ff <= write_next;
                  accepted_ff    <= 1'b1;
                  if (!playing_ff) begin
                     // Idle queue: the new tone starts at once.
                     out_freq_ff   <= pend_freq_ff;
                     out_duty_ff   <= pend_duty_ff;
                     playing_ff    <= 1'b1;
                     read_index_ff <= read_next;
                     changed_ff    <= 1'b1;
                     state_ff      <= ST_MUL;
                  end else begin
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= ST_IDLE;
                  end
               end
            end
            ST_LOAD: begin
               out_freq_ff   <= rd_tone.freq;
               out_duty_ff   <= rd_tone.duty;
               pend_dur_ff   <= rd_tone.dur;
               read_index_ff <= read_next;
               state_ff      <= ST_MUL;
            end
            ST_MUL: begin
               scale_hi_ff <= mul_hi;
               scale_lo_ff <= mul_lo;
               state_ff    <= ST_SCALE;
            end
            ST_SCALE: begin
               scale_q_ff <= recip_full[SCALE_PROD_W-1:MS_RECIP_SHIFT];
               state_ff   <= ST_SUM;
            end
            ST_SUM: begin
               ticks_ff     <= TICK_W'(scale_hi_ff) + TICK_W'(scale_q_ff);
               rsp_valid_ff <= 1'b1;
               state_ff     <= ST_IDLE;
            end
         endcase
      end
   end

   // Ports.
   assign busy            = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_accepted    = accepted_ff;
   assign rsp_pwm_changed = changed_ff;
   assign rsp_pwm_freq    = out_freq_ff;
   assign rsp_pwm_duty    = out_duty_ff;
   assign rsp_playing     = playing_ff;

   `PTS_ASSERT_SAME(a_rsp_only_when_idle, clock, reset, rsp_valid_ff, state_ff == ST_IDLE)
   `PTS_ASSERT_SAME(a_stopped_output_zero, clock, reset, !playing_ff,
                    (out_freq_ff == '0) && (out_duty_ff == '0))
   `PTS_ASSERT_SAME(a_no_write_when_full, clock, reset, wr_en, write_next != read_index_ff)

endmodule
